FILE: src/bced_pkg.sv
// Shared types and constants for the button click event detector.
// No dependencies; imported by the top level and its port checker.
package bced_pkg;

  localparam int FlagW = 7;
  localparam int TickW = 8;
  localparam int CountW = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  // Event flag bit positions.
  localparam int EvHold = 0;
  localparam int EvDown = 1;
  localparam int EvUp = 2;
  localparam int EvSingle = 3;
  localparam int EvDouble = 4;
  localparam int EvLong = 5;
  localparam int EvRepeat = 6;

  localparam logic [TickW-1:0] SamplePeriodRst = 8'd20;
  localparam logic [CountW-1:0] LongPressRst = 16'd1600;
  localparam logic [CountW-1:0] DoubleWindowRst = 16'd200;
  localparam logic [CountW-1:0] RepeatRst = 16'd100;

  typedef enum logic [2:0] {
    STAGE_IDLE     = 3'd0,
    STAGE_PRESSED  = 3'd1,
    STAGE_RELEASED = 3'd2,
    STAGE_DOUBLE   = 3'd3,
    STAGE_LONG     = 3'd4
  } stage_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_PERIOD = 2'd0,
    CFG_LONG_PRESS    = 2'd1,
    CFG_DOUBLE_WINDOW = 2'd2,
    CFG_REPEAT        = 2'd3
  } cfg_index_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_CHECK = 1'b1
  } cmd_t;

endpackage

FILE: src/button_click_event_detector_unit.sv
// Button click event detector: tick/check item channel, result channel, config port.
// Depends on bced_pkg.
//
// Each accepted item (a millisecond tick with the active-low pin level, or a
// check with an event mask) produces exactly one result: hit and the event flags
// as they stand after the item. All work for an item is done in the cycle it is
// accepted, so one item is taken per clock while in_stall is low; a two-entry
// result buffer (output register plus skid stage) lets the input take one more
// item while a result is stalled, and in_stall rises only when both entries are full.
// Configuration writes are always ready and should only be issued while idle.
module button_click_event_detector_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              cmd,
  input  logic                              pin_level,
  input  logic [bced_pkg::FlagW-1:0]        event_mask,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              hit,
  output logic [bced_pkg::FlagW-1:0]        event_flags,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bced_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bced_pkg::CfgDataW-1:0]     cfg_data
);

  import bced_pkg::*;

  logic [TickW-1:0]  sample_period;
  logic [CountW-1:0] long_press_ticks;
  logic [CountW-1:0] double_window_ticks;
  logic [CountW-1:0] repeat_ticks;

  logic [TickW-1:0]  tick_count, tick_count_next;
  logic [CountW-1:0] countdown, countdown_next;
  logic              now_pressed, now_pressed_next;
  logic              was_pressed, was_pressed_next;
  stage_t            stage, stage_next;
  logic [FlagW-1:0]  flags, flags_next;
  logic              hit_next;

  logic              skid_valid;
  logic              skid_hit;
  logic [FlagW-1:0]  skid_flags;

  logic              in_accept;
  logic              out_free;
  logic [TickW-1:0]  tick_inc;
  logic [FlagW-1:0]  clear_mask;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period       <= SamplePeriodRst;
      long_press_ticks    <= LongPressRst;
      double_window_ticks <= DoubleWindowRst;
      repeat_ticks        <= RepeatRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_SAMPLE_PERIOD: sample_period       <= cfg_data[TickW-1:0];
        CFG_LONG_PRESS:    long_press_ticks    <= cfg_data[CountW-1:0];
        CFG_DOUBLE_WINDOW: double_window_ticks <= cfg_data[CountW-1:0];
        CFG_REPEAT:        repeat_ticks        <= cfg_data[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tick_count_next  = tick_count;
    countdown_next   = countdown;
    now_pressed_next = now_pressed;
    was_pressed_next = was_pressed;
    stage_next       = stage;
    flags_next       = flags;
    hit_next         = 1'b0;
    tick_inc         = tick_count + TickW'(1);
    clear_mask       = event_mask;
    clear_mask[EvHold] = 1'b0;

    if (cmd == CMD_TICK) begin
      tick_count_next = tick_inc;
      if (countdown != '0) begin
        countdown_next = countdown - CountW'(1);
      end
      // A period of zero never exceeds the count, so every tick samples.
      if (tick_inc >= sample_period) begin
        tick_count_next  = '0;
        was_pressed_next = now_pressed;
        now_pressed_next = !pin_level;
        flags_next[EvHold] = !pin_level;
        if (!pin_level && !now_pressed) begin
          flags_next[EvDown] = 1'b1;
        end
        if (pin_level && now_pressed) begin
          flags_next[EvUp] = 1'b1;
        end
        unique case (stage)
          STAGE_IDLE: begin
            if (!pin_level) begin
              countdown_next = long_press_ticks;
              stage_next     = STAGE_PRESSED;
            end
          end
          STAGE_PRESSED: begin
            if (pin_level) begin
              countdown_next = double_window_ticks;
              stage_next     = STAGE_RELEASED;
            end else if (countdown_next == '0) begin
              flags_next[EvLong] = 1'b1;
              countdown_next     = repeat_ticks;
              stage_next         = STAGE_LONG;
            end
          end
          STAGE_RELEASED: begin
            if (!pin_level) begin
              flags_next[EvDouble] = 1'b1;
              stage_next           = STAGE_DOUBLE;
            end else if (countdown_next == '0) begin
              flags_next[EvSingle] = 1'b1;
              stage_next           = STAGE_IDLE;
            end
          end
          STAGE_DOUBLE: begin
            if (pin_level) begin
              stage_next = STAGE_IDLE;
            end
          end
          STAGE_LONG: begin
            if (pin_level) begin
              stage_next = STAGE_IDLE;
            end else if (countdown_next == '0) begin
              flags_next[EvRepeat] = 1'b1;
              countdown_next       = repeat_ticks;
            end
          end
          default: ;
        endcase
      end
    end else begin
      // The hold flag counts toward a hit but only the pin clears it.
      if ((flags & event_mask) != '0) begin
        hit_next   = 1'b1;
        flags_next = flags & ~clear_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      countdown   <= '0;
      now_pressed <= 1'b0;
      was_pressed <= 1'b0;
      stage       <= STAGE_IDLE;
      flags       <= '0;
    end else if (in_accept) begin
      tick_count  <= tick_count_next;
      countdown   <= countdown_next;
      now_pressed <= now_pressed_next;
      was_pressed <= was_pressed_next;
      stage       <= stage_next;
      flags       <= flags_next;
    end
  end

  // Result buffer: the skid entry only fills while the output register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        hit         <= skid_hit;
        event_flags <= skid_flags;
      end else if (in_accept) begin
        hit         <= hit_next;
        event_flags <= flags_next;
      end
    end else if (in_accept) begin
      skid_hit   <= hit_next;
      skid_flags <= flags_next;
    end
  end

endmodule

FILE: src/bced_checker.sv
// Port-level checker for the button click event detector, bound to the top level.
// Depends on bced_pkg and button_click_event_detector_unit.
module bced_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          hit,
  input logic [bced_pkg::FlagW-1:0]    event_flags
);

  import bced_pkg::*;

  // A stalled result must hold its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(event_flags))
    else $error("stalled result changed");

  // The input only stalls when a result is already waiting at the output.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // Once the output drains, the skid entry moves up and the input frees.
  assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |=> !in_stall && out_valid)
    else $error("skid entry not drained");

  // Reset empties the result buffer.
  assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result buffer not empty after reset");

endmodule

bind button_click_event_detector_unit bced_checker u_bced_checker (.*);

FILE: tb/tb_button_click_event_detector_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_click_event_detector_unit.
// Depends on bced_pkg and the detector RTL; predicts every result internally.
module tb_button_click_event_detector_unit;
  import bced_pkg::*;

  localparam int HoldOffCycles = 40;

  typedef struct packed {
    logic             hit;
    logic [FlagW-1:0] flags;
  } click_result_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic cmd;
  logic pin_level;
  logic [FlagW-1:0] event_mask;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [FlagW-1:0] event_flags;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Shadow copy of the detector's registers and state.
  logic [TickW-1:0] period_reg;
  logic [CountW-1:0] long_reg;
  logic [CountW-1:0] window_reg;
  logic [CountW-1:0] repeat_reg;
  logic [TickW-1:0] tick_cnt;
  logic [CountW-1:0] cdown;
  logic pressed_now;
  logic pressed_prev;
  stage_t stage_q;
  logic [FlagW-1:0] ev_flags;

  click_result_t pending_results[$];
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  button_click_event_detector_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .pin_level(pin_level),
    .event_mask(event_mask),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .event_flags(event_flags),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  task predict_button_events(input cmd_t c, input logic pin, input logic [FlagW-1:0] mask,
                             output click_result_t res);
    logic [FlagW-1:0] keep;
    res.hit = 1'b0;
    if (c == CMD_TICK) begin
      tick_cnt = tick_cnt + 1'b1;
      if (cdown != '0) cdown = cdown - 1'b1;
      if (tick_cnt >= period_reg) begin
        tick_cnt = '0;
        pressed_prev = pressed_now;
        pressed_now = (pin == 1'b0);
        ev_flags[EvHold] = pressed_now;
        if (pressed_now && !pressed_prev) ev_flags[EvDown] = 1'b1;
        if (!pressed_now && pressed_prev) ev_flags[EvUp] = 1'b1;
        case (stage_q)
          STAGE_IDLE: begin
            if (pressed_now) begin
              cdown = long_reg;
              stage_q = STAGE_PRESSED;
            end
          end
          STAGE_PRESSED: begin
            if (!pressed_now) begin
              cdown = window_reg;
              stage_q = STAGE_RELEASED;
            end else if (cdown == '0) begin
              ev_flags[EvLong] = 1'b1;
              cdown = repeat_reg;
              stage_q = STAGE_LONG;
            end
          end
          STAGE_RELEASED: begin
            if (pressed_now) begin
              ev_flags[EvDouble] = 1'b1;
              stage_q = STAGE_DOUBLE;
            end else if (cdown == '0) begin
              ev_flags[EvSingle] = 1'b1;
              stage_q = STAGE_IDLE;
            end
          end
          STAGE_DOUBLE: begin
            if (!pressed_now) stage_q = STAGE_IDLE;
          end
          STAGE_LONG: begin
            if (!pressed_now) begin
              stage_q = STAGE_IDLE;
            end else if (cdown == '0) begin
              ev_flags[EvRepeat] = 1'b1;
              cdown = repeat_reg;
            end
          end
          default: ;
        endcase
      end
    end else if ((ev_flags & mask) != '0) begin
      // The hold flag tracks the pin and survives a check.
      keep = mask;
      keep[EvHold] = 1'b0;
      res.hit = 1'b1;
      ev_flags = ev_flags & ~keep;
    end
    res.flags = ev_flags;
  endtask

  // Prediction on accepted inputs and register writes, checking on accepted results.
  always @(posedge clk) begin
    click_result_t exp_res;
    if (rst) begin
      period_reg = SamplePeriodRst;
      long_reg = LongPressRst;
      window_reg = DoubleWindowRst;
      repeat_reg = RepeatRst;
      tick_cnt = '0;
      cdown = '0;
      pressed_now = 1'b0;
      pressed_prev = 1'b0;
      stage_q = STAGE_IDLE;
      ev_flags = '0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_PERIOD: period_reg = cfg_data[TickW-1:0];
          CFG_LONG_PRESS:    long_reg = cfg_data;
          CFG_DOUBLE_WINDOW: window_reg = cfg_data;
          CFG_REPEAT:        repeat_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_button_events(cmd_t'(cmd), pin_level, event_mask, exp_res);
        pending_results.push_back(exp_res);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no transaction outstanding, actual hit %0b flags %h",
                   $time, hit, event_flags);
        end else begin
          exp_res = pending_results.pop_front();
          if (hit !== exp_res.hit) begin
            mismatch_count++;
            $display("%0t: hit mismatch, expected %0b, actual %0b", $time, exp_res.hit, hit);
          end
          if (event_flags !== exp_res.flags) begin
            mismatch_count++;
            $display("%0t: event_flags mismatch, expected %h, actual %h",
                     $time, exp_res.flags, event_flags);
          end
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_item(input cmd_t c, input logic pin, input logic [FlagW-1:0] mask);
    // Each cycle the sender stays idle with the phase's probability.
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= c;
    pin_level <= pin;
    event_mask <= mask;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [TickW-1:0] period, input logic [CountW-1:0] lp,
                              input logic [CountW-1:0] dw, input logic [CountW-1:0] rp);
    // Upper data bits of the sample period write are don't-care.
    write_reg(CFG_SAMPLE_PERIOD, {8'($urandom), period});
    write_reg(CFG_LONG_PRESS, lp);
    write_reg(CFG_DOUBLE_WINDOW, dw);
    write_reg(CFG_REPEAT, rp);
  endtask

  // Press and release runs of random length, with checks and pin noise mixed in.
  task automatic drive_button_activity(input int n_items, input int max_run);
    int sent;
    int run;
    int roll;
    logic level;
    logic [FlagW-1:0] mask;
    sent = 0;
    level = 1'b1;
    while (sent < n_items) begin
      run = $urandom_range(1, max_run);
      level = ~level;
      for (int k = 0; k < run && sent < n_items; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          case ($urandom_range(0, 7))
            0: mask = '0;
            1, 2: mask = '1;
            default: mask = FlagW'($urandom);
          endcase
          send_item(CMD_CHECK, 1'($urandom), mask);
        end else if (roll < 16) begin
          send_item(CMD_TICK, 1'($urandom), FlagW'($urandom));
        end else begin
          send_item(CMD_TICK, level, FlagW'($urandom));
        end
        sent++;
      end
    end
  endtask

  task automatic test_defaults_after_reset();
    sender_idle_pct = 0;
    stall_pct <= 0;
    // Two samples at the default period, both pressed.
    for (int i = 0; i < 44; i++) send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_CHECK, 1'b1, '1);
    wait_idle();
  endtask

  task automatic test_directed_sequences();
    program_regs(8'd1, 16'd2, 16'd2, 16'd1);
    send_item(CMD_CHECK, 1'b0, '0);
    // Release after the earlier press, then let the window run out: single click.
    send_item(CMD_TICK, 1'b1, '0);
    send_item(CMD_TICK, 1'b1, '0);
    send_item(CMD_TICK, 1'b1, '0);
    send_item(CMD_CHECK, 1'b0, '1);
    send_item(CMD_CHECK, 1'b1, '1);
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_CHECK, 1'b0, 7'h01);
    // Release and press again inside the window: double click.
    send_item(CMD_TICK, 1'b1, '0);
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_TICK, 1'b1, '0);
    // Held past the long-press time, then two repeats.
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_TICK, 1'b0, '0);
    send_item(CMD_CHECK, 1'b0, '1);
    send_item(CMD_TICK, 1'b1, '1);
    send_item(CMD_CHECK, 1'b0, 7'h7E);
    send_item(CMD_TICK, 1'b0, '1);
    wait_idle();
  endtask

  task automatic test_zero_timing();
    program_regs(8'd1, 16'd0, 16'd0, 16'd0);
    drive_button_activity(80, 8);
    wait_idle();
  endtask

  task automatic test_sample_every_tick();
    sender_idle_pct = 46;
    program_regs(8'd0, 16'($urandom_range(2, 12)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 4)));
    drive_button_activity(90, 24);
    wait_idle();
  endtask

  task automatic test_receiver_stalls();
    sender_idle_pct = 0;
    stall_pct <= 46;
    program_regs(8'($urandom_range(2, 4)), 16'($urandom_range(10, 40)),
                 16'($urandom_range(5, 20)), 16'($urandom_range(3, 10)));
    drive_button_activity(90, 70);
    wait_idle();
  endtask

  task automatic test_maximum_settings();
    sender_idle_pct = 28;
    stall_pct <= 28;
    program_regs(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drive_button_activity(320, 300);
    wait_idle();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct <= 0;
    program_regs(8'd1, 16'd8, 16'd6, 16'd3);
    hold_seq <= hold_seq + 1;
    drive_button_activity(60, 20);
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_TICK;
    pin_level <= 1'b1;
    event_mask <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SAMPLE_PERIOD;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults_after_reset();
    test_directed_sequences();
    test_zero_timing();
    test_sample_every_tick();
    test_receiver_stalls();
    test_maximum_settings();
    test_backpressure();

    stall_pct <= 0;
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
